### rtl/bytewise_bitvector_rule_classifier_top_defines.svh
// Assertion macros used by the checker file.
`ifndef BYTEWISE_BITVECTOR_RULE_CLASSIFIER_TOP_DEFINES_SVH
`define BYTEWISE_BITVECTOR_RULE_CLASSIFIER_TOP_DEFINES_SVH
// Asserts that an implication holds at every clock edge outside reset.
`define BBRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Asserts that a condition holds in the cycle after the antecedent.
`define BBRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/bbrc_pkg.sv
// ----------------------------------------------------------------------------
// bbrc_pkg
// Types and constants of the byte-wise bit-vector rule classifier.
// ----------------------------------------------------------------------------
package bbrc_pkg;
    localparam int MAX_RULES  = 256;
    localparam int MAX_TABLES = 37;
    localparam int CHUNK_BITS = 64;
    localparam int CHUNKS     = MAX_RULES / CHUNK_BITS;
    localparam int ROWS       = 256;
    localparam int CW         = $clog2(CHUNKS);
    localparam int RW         = $clog2(MAX_RULES);
    localparam int TW         = 6;
    localparam int MEM_DEPTH  = MAX_TABLES * ROWS * CHUNKS;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam logic [5:0] TABLES_RESET = 6'd13;

    typedef enum logic [1:0] {
        KIND_RULE    = 2'd0,
        KIND_PATTERN = 2'd1,
        KIND_BYTE    = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_BADTAB  = 3'd3,
        ST_KEYLEN  = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] rule_number;
        logic [5:0]  table_index;
        logic [7:0]  match_byte;
        logic [7:0]  mask_byte;
        logic [7:0]  packet_byte;
        logic        last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  chunk_index;
        logic [63:0] candidate_bits;
        logic        any_candidate;
        logic [5:0]  first_candidate;
        logic        last_result;
    } out_item_t;
endpackage

### rtl/bbrc_fifo.sv
// ----------------------------------------------------------------------------
// bbrc_fifo
// Two-entry queue that decouples the front part from the engine.
// ----------------------------------------------------------------------------
module bbrc_fifo
    import bbrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr,
    input  in_item_t wdata,
    output logic     full,
    input  logic     rd,
    output in_item_t rdata,
    output logic     empty
);
    in_item_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
        end
    end
endmodule

### rtl/bbrc_engine.sv
// ----------------------------------------------------------------------------
// bbrc_engine
// Sequencer that executes rule, pattern and packet-byte items on the tables.
// ----------------------------------------------------------------------------
module bbrc_engine
    import bbrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [5:0] tables_in_use,
    input  in_item_t  item,
    input  logic      item_valid,
    output logic      item_take,
    output out_item_t res,
    output logic      res_valid,
    input  logic      res_take
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_DUP, S_DUPCHK, S_CLR, S_PROG_RD, S_PROG_WR,
        S_BYTE_RD, S_BYTE_AND, S_EMIT, S_WAIT, S_INIT
    } state_t;

    state_t      state_reg;
    logic [63:0] mem [MEM_DEPTH];
    logic [31:0] num_mem [MAX_RULES];
    logic [63:0] rdata_reg;
    logic [31:0] num_rd_reg;
    logic [AW-1:0] clr_reg;
    logic [8:0]  rule_count_reg;
    logic [5:0]  byte_pos_reg;
    logic [63:0] cand_reg [CHUNKS];
    in_item_t    it_reg;
    logic [8:0]  idx_reg;
    logic [5:0]  tab_reg;
    logic [8:0]  row_reg;
    logic [CW:0] ch_reg;
    logic        keyerr_reg;
    out_item_t   res_reg;
    logic        res_valid_reg;

    logic [5:0]  nt;
    logic [AW-1:0] addr;
    logic        mem_we;
    logic [63:0] mem_wd;
    logic [RW-1:0] r_new;
    logic [CW:0] used;
    logic [63:0] vmask;
    logic [63:0] cbits;
    logic [5:0]  first;
    logic [8:0]  base;

    assign nt = (tables_in_use == 6'd0) ? 6'd1 :
                (tables_in_use > 6'(MAX_TABLES)) ? 6'(MAX_TABLES) : tables_in_use;
    assign r_new = RW'(rule_count_reg - 9'd1);
    assign used  = (rule_count_reg == 9'd0) ? (CW+1)'(1) : (CW+1)'((rule_count_reg + 9'd63) >> 6);
    assign item_take = (state_reg == S_IDLE) && item_valid && !res_valid_reg;
    assign res = res_reg;
    assign res_valid = res_valid_reg;

    // Address: table, row, chunk.
    always_comb
    begin
        addr   = '0;
        mem_we = 1'b0;
        mem_wd = rdata_reg;
        unique case (state_reg)
            S_INIT:
            begin
                addr   = clr_reg;
                mem_we = 1'b1;
                mem_wd = '0;
            end
            S_CLEAR, S_CLR:
            begin
                addr = AW'((32'(tab_reg) * ROWS + 32'(row_reg[7:0])) * CHUNKS
                       + 32'(rule_count_reg[RW-1:6]));
                mem_we = (state_reg == S_CLR);
                mem_wd = rdata_reg & ~(64'd1 << rule_count_reg[5:0]);
            end
            S_PROG_RD, S_PROG_WR:
            begin
                addr = AW'((32'(it_reg.table_index) * ROWS + 32'(row_reg[7:0])) * CHUNKS
                       + 32'(r_new[RW-1:6]));
                mem_we = (state_reg == S_PROG_WR) &&
                         (((row_reg[7:0] ^ it_reg.match_byte) & ~it_reg.mask_byte) == 8'd0);
                mem_wd = rdata_reg | (64'd1 << r_new[5:0]);
            end
            S_BYTE_RD:
            begin
                addr = AW'((32'(byte_pos_reg) * ROWS + 32'(it_reg.packet_byte)) * CHUNKS
                       + 32'(ch_reg[CW-1:0]));
            end
            default:
            begin
                addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= mem_wd;
        end
        rdata_reg  <= mem[addr];
        num_rd_reg <= num_mem[idx_reg[RW-1:0]];
        if (state_reg == S_DUPCHK && idx_reg == rule_count_reg && rule_count_reg != 9'(MAX_RULES))
        begin
            num_mem[rule_count_reg[RW-1:0]] <= it_reg.rule_number;
        end
    end

    always_comb
    begin
        base  = 9'({ch_reg[CW-1:0], 6'd0});
        if (rule_count_reg <= base)
        begin
            vmask = '0;
        end
        else if (rule_count_reg - base >= 9'd64)
        begin
            vmask = '1;
        end
        else
        begin
            vmask = (64'd1 << (rule_count_reg - base)) - 64'd1;
        end
        cbits = cand_reg[ch_reg[CW-1:0]] & vmask;
        first = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (cbits[i])
            begin
                first = 6'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            clr_reg        <= '0;
            rule_count_reg <= '0;
            byte_pos_reg   <= '0;
            for (int c = 0; c < CHUNKS; c++)
            begin
                cand_reg[c] <= '1;
            end
            res_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            tab_reg        <= '0;
            row_reg        <= '0;
            ch_reg         <= '0;
            keyerr_reg     <= 1'b0;
            it_reg         <= '0;
            res_reg        <= '0;
        end
        else
        begin
            if (res_valid_reg && res_take)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MEM_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item_take)
                    begin
                        it_reg  <= item;
                        idx_reg <= '0;
                        row_reg <= '0;
                        tab_reg <= '0;
                        ch_reg  <= '0;
                        res_reg <= '0;
                        res_reg.last_result <= 1'b1;
                        unique case (kind_t'(item.kind))
                            KIND_RULE:    state_reg <= S_DUP;
                            KIND_PATTERN:
                            begin
                                if (rule_count_reg == 9'd0 || item.table_index >= nt)
                                begin
                                    res_reg.status <= ST_BADTAB;
                                    res_valid_reg  <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_PROG_RD;
                                end
                            end
                            KIND_BYTE:
                            begin
                                keyerr_reg <= 1'b0;
                                state_reg  <= S_BYTE_RD;
                            end
                            default:      state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_DUP:
                begin
                    // Number read of entry idx_reg appears next cycle.
                    state_reg <= S_DUPCHK;
                end
                S_DUPCHK:
                begin
                    if (idx_reg == rule_count_reg)
                    begin
                        if (rule_count_reg == 9'(MAX_RULES))
                        begin
                            res_reg.status <= ST_FULL;
                            res_valid_reg  <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_CLEAR;
                        end
                    end
                    else if (num_rd_reg == it_reg.rule_number)
                    begin
                        res_reg.status <= ST_DUP;
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 9'd1;
                        state_reg <= S_DUP;
                    end
                end
                S_CLEAR:
                begin
                    state_reg <= S_CLR;
                end
                S_CLR:
                begin
                    if (row_reg == 9'd255)
                    begin
                        row_reg <= '0;
                        if (tab_reg == 6'(MAX_TABLES - 1))
                        begin
                            rule_count_reg <= rule_count_reg + 9'd1;
                            res_reg.status <= ST_OK;
                            res_valid_reg  <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            tab_reg   <= tab_reg + 6'd1;
                            state_reg <= S_CLEAR;
                        end
                    end
                    else
                    begin
                        row_reg   <= row_reg + 9'd1;
                        state_reg <= S_CLEAR;
                    end
                end
                S_PROG_RD:
                begin
                    state_reg <= S_PROG_WR;
                end
                S_PROG_WR:
                begin
                    if (row_reg == 9'd255)
                    begin
                        res_reg.status <= ST_OK;
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 9'd1;
                        state_reg <= S_PROG_RD;
                    end
                end
                S_BYTE_RD:
                begin
                    if (byte_pos_reg < nt)
                    begin
                        state_reg <= S_BYTE_AND;
                    end
                    else
                    begin
                        ch_reg <= (CW+1)'(CHUNKS);
                        state_reg <= S_BYTE_AND;
                    end
                end
                S_BYTE_AND:
                begin
                    if (ch_reg < (CW+1)'(CHUNKS))
                    begin
                        cand_reg[ch_reg[CW-1:0]] <= cand_reg[ch_reg[CW-1:0]] & rdata_reg;
                    end
                    if (ch_reg < (CW+1)'(CHUNKS - 1))
                    begin
                        ch_reg    <= ch_reg + (CW+1)'(1);
                        state_reg <= S_BYTE_RD;
                    end
                    else
                    begin
                        ch_reg <= '0;
                        if (byte_pos_reg < 6'd63)
                        begin
                            byte_pos_reg <= byte_pos_reg + 6'd1;
                        end
                        if (it_reg.last_byte)
                        begin
                            keyerr_reg <= ((byte_pos_reg < 6'd63 ? byte_pos_reg + 6'd1
                                                                : byte_pos_reg) != nt);
                            state_reg  <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!res_valid_reg || res_take)
                    begin
                        res_valid_reg <= 1'b1;
                        if (keyerr_reg)
                        begin
                            res_reg <= '0;
                            res_reg.status <= ST_KEYLEN;
                            res_reg.last_result <= 1'b1;
                            state_reg <= S_WAIT;
                        end
                        else
                        begin
                            res_reg.status          <= ST_OK;
                            res_reg.chunk_index     <= 2'(ch_reg[CW-1:0]);
                            res_reg.candidate_bits  <= cbits;
                            res_reg.any_candidate   <= (cbits != 64'd0);
                            res_reg.first_candidate <= first;
                            res_reg.last_result     <= (ch_reg + (CW+1)'(1) == used);
                            if (ch_reg + (CW+1)'(1) == used)
                            begin
                                state_reg <= S_WAIT;
                            end
                            else
                            begin
                                ch_reg <= ch_reg + (CW+1)'(1);
                            end
                        end
                    end
                end
                S_WAIT:
                begin
                    for (int c = 0; c < CHUNKS; c++)
                    begin
                        cand_reg[c] <= '1;
                    end
                    byte_pos_reg <= '0;
                    ch_reg       <= '0;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

### rtl/bytewise_bitvector_rule_classifier_top.sv
// ----------------------------------------------------------------------------
// bytewise_bitvector_rule_classifier_top
// Byte-wise bit-vector rule classifier with decoupled queue and engine.
// ----------------------------------------------------------------------------
// The engine takes an item in the cycle after its input transfer at the earliest, one at a time,
// and takes none while its result register still waits to be popped.
// A packet byte is taken, then runs four chunk read and merge pairs on the single table memory
// port, or one read and no merge past the table count; a key end emits one result per used chunk.
// A rule append checks the stored rule numbers, then clears its bit in each row of all 37 tables;
// a pattern sets it in matching rows, a refused one only gets a status. Reset clears all tables.
module bytewise_bitvector_rule_classifier_top
    import bbrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [5:0] cfg_data,
    input  logic      push,
    input  in_item_t  in_item,
    output logic      full,
    input  logic      pop,
    output out_item_t out_item,
    output logic      empty
);
    logic [5:0] tables_reg;
    in_item_t   q_item;
    logic       q_empty;
    logic       q_take;
    logic       rv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tables_reg <= TABLES_RESET;
        end
        else if (cfg_we)
        begin
            tables_reg <= cfg_data;
        end
    end

    bbrc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (in_item),
        .full  (full),
        .rd    (q_take),
        .rdata (q_item),
        .empty (q_empty)
    );

    bbrc_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .tables_in_use (tables_reg),
        .item          (q_item),
        .item_valid    (!q_empty),
        .item_take     (q_take),
        .res           (out_item),
        .res_valid     (rv),
        .res_take      (pop)
    );

    assign empty = !rv;
endmodule

### rtl/bbrc_checker.sv
// ----------------------------------------------------------------------------
// bbrc_checker
// Port-level checks of the classifier's result stream.
// ----------------------------------------------------------------------------
`include "bytewise_bitvector_rule_classifier_top_defines.svh"
module bbrc_checker
    import bbrc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);
    logic any_ok;
    logic is_err;
    logic err_shape;
    logic first_set;

    assign any_ok    = out_item.any_candidate == (out_item.candidate_bits != 64'd0);
    assign is_err    = out_item.status != ST_OK;
    assign err_shape = out_item.last_result && (out_item.candidate_bits == 64'd0);
    assign first_set = out_item.candidate_bits[out_item.first_candidate];

    `BBRC_ASSERT_IMP(a_any, clk, rst_n, !empty, any_ok)
    `BBRC_ASSERT_IMP(a_err_last, clk, rst_n, !empty && is_err, err_shape)
    `BBRC_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item))
    `BBRC_ASSERT_IMP(a_first, clk, rst_n, !empty && out_item.any_candidate, first_set)
endmodule

bind bytewise_bitvector_rule_classifier_top bbrc_checker u_bbrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
